// File: rtl/mpts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mpts_pkg;

    // Table geometry and counter widths.
    localparam int SLOTS   = 16;
    localparam int SLOT_W  = 4;
    localparam int IDX_W   = 5;
    localparam int CNT_W   = 24;
    localparam logic [CNT_W-1:0] CNT_MAX = 24'hFFFFFF;

    // Item kinds; the last code is not defined and only reports status.
    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_TICK    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    // Scheduling policies.
    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_SJF  = 2'd1;
    localparam logic [1:0] POL_RR   = 2'd2;
    localparam logic [1:0] POL_PRIO = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = 2'd1;

    // One row of the slot table.
    typedef struct packed {
        logic [15:0]      arrival;
        logic [15:0]      remaining;
        logic [7:0]       prio;
        logic [CNT_W-1:0] start;
        logic [CNT_W-1:0] wait_cnt;
    } slot_row_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ADMIT,
        ST_REQUEUE,
        ST_DECIDE,
        ST_SELECT,
        ST_TAKE,
        ST_RUN_RD,
        ST_RUN_WR,
        ST_WAIT_RD,
        ST_WAIT_WR,
        ST_FINISH
    } state_t;

    // Saturating increment of a 24-bit counter.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mpts_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input item channel.
interface mpts_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;

    modport source (output valid, kind, slot, arrival, burst, prio, input ready);
    modport sink   (input valid, kind, slot, arrival, burst, prio, output ready);
endinterface

// Result channel.
interface mpts_result_if;
    logic        valid;
    logic        ready;
    logic [23:0] clock_now;
    logic        running_valid;
    logic [3:0]  running_slot;
    logic        done_valid;
    logic [3:0]  done_slot;
    logic [23:0] done_wait;
    logic [23:0] done_response;
    logic [23:0] done_turnaround;
    logic        all_done;
    logic [23:0] busy_ticks;
    logic        load_error;

    modport source (output valid, clock_now, running_valid, running_slot, done_valid,
                    done_slot, done_wait, done_response, done_turnaround, all_done,
                    busy_ticks, load_error, input ready);
    modport sink   (input valid, clock_now, running_valid, running_slot, done_valid,
                    done_slot, done_wait, done_response, done_turnaround, all_done,
                    busy_ticks, load_error, output ready);
endinterface

// Configuration write channel.
interface mpts_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [7:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/mpts_slot_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Slot table: one write port, one read port with registered read data.
module mpts_slot_ram (
    input  wire                               clk,
    input  wire  [mpts_pkg::SLOT_W-1:0]       rd_addr,
    output mpts_pkg::slot_row_t               rd_data,
    input  wire                               wr_en,
    input  wire  [mpts_pkg::SLOT_W-1:0]       wr_addr,
    input  wire  mpts_pkg::slot_row_t         wr_data
);

    mpts_pkg::slot_row_t mem [mpts_pkg::SLOTS];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: rtl/multi_policy_tick_scheduler_top.sv
// Channel   Dir  Handshake      Payload
// item      in   valid/ready    kind, slot, arrival, burst, prio
// result    out  valid/ready    clock_now, running/done fields, all_done, busy_ticks, load_error
// cfg       in   valid/ready    index (0 policy, 1 quantum), data
//
// One item is in work at a time. A restart or unknown item goes straight to the result
// step; a load writes its slot first. A tick sweeps the slot table through the single
// read port: it admits arrivals, requeues, decides, selects (SJF and priority only),
// dispatches, runs the current slot, charges wait time to each queued slot and hands
// over the result. The result register lets the next item be accepted while a result
// beat still waits; a second result holds the block in its last step until that beat
// is taken. Reset clears the control state and the per-slot flags; the slot table
// needs no clearing since its data is used only for loaded slots.
`timescale 1ns / 1ps
`default_nettype none

module multi_policy_tick_scheduler_top (
    input wire               clk,
    input wire               rst_n,
    mpts_item_if.sink        item,
    mpts_result_if.source    result,
    mpts_cfg_if.sink         cfg
);

    localparam int SL = mpts_pkg::SLOTS;
    localparam int SW = mpts_pkg::SLOT_W;
    localparam int IW = mpts_pkg::IDX_W;
    localparam int CW = mpts_pkg::CNT_W;

    mpts_pkg::state_t state_reg, state_next;
    logic [1:0]  policy_reg, policy_next;
    logic [7:0]  quantum_reg, quantum_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [15:0] arr_reg, arr_next;
    logic [15:0] burst_reg, burst_next;
    logic [7:0]  prio_reg, prio_next;

    logic [SL-1:0] valid_reg, valid_next;
    logic [SL-1:0] started_reg, started_next;
    logic [SL-1:0] ready_reg, ready_next;
    logic [SL-1:0] completed_reg, completed_next;
    logic [SW-1:0] q_reg [SL];
    logic [SW-1:0] q_next [SL];
    logic [IW-1:0] qcnt_reg, qcnt_next;

    logic          cur_v_reg, cur_v_next;
    logic [SW-1:0] cur_slot_reg, cur_slot_next;
    logic [7:0]    cur_prio_reg, cur_prio_next;
    logic [7:0]    slice_reg, slice_next;
    logic          req_v_reg, req_v_next;
    logic [SW-1:0] req_slot_reg, req_slot_next;
    logic [CW-1:0] clock_reg, clock_next;
    logic [CW-1:0] busy_reg, busy_next;

    logic [IW-1:0] idx_reg, idx_next;
    logic          pend_reg, pend_next;
    logic [SW-1:0] pidx_reg, pidx_next;
    logic [15:0]   best_reg, best_next;
    logic [SW-1:0] bp_reg, bp_next;

    logic          res_run_v_reg, res_run_v_next;
    logic [SW-1:0] res_run_slot_reg, res_run_slot_next;
    logic          res_done_v_reg, res_done_v_next;
    logic [SW-1:0] res_done_slot_reg, res_done_slot_next;
    logic [CW-1:0] res_wait_reg, res_wait_next;
    logic [CW-1:0] res_resp_reg, res_resp_next;
    logic [CW-1:0] res_turn_reg, res_turn_next;
    logic          res_err_reg, res_err_next;

    logic          out_v_reg, out_v_next;
    logic [CW-1:0] out_clock_reg, out_clock_next;
    logic          out_run_v_reg, out_run_v_next;
    logic [SW-1:0] out_run_slot_reg, out_run_slot_next;
    logic          out_done_v_reg, out_done_v_next;
    logic [SW-1:0] out_done_slot_reg, out_done_slot_next;
    logic [CW-1:0] out_wait_reg, out_wait_next;
    logic [CW-1:0] out_resp_reg, out_resp_next;
    logic [CW-1:0] out_turn_reg, out_turn_next;
    logic          out_all_reg, out_all_next;
    logic [CW-1:0] out_busy_reg, out_busy_next;
    logic          out_err_reg, out_err_next;

    // Slot table memory.
    logic [SW-1:0]       rd_addr;
    mpts_pkg::slot_row_t rd_data;
    logic                wr_en;
    logic [SW-1:0]       wr_addr;
    mpts_pkg::slot_row_t wr_data;

    mpts_slot_ram u_ram (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Handshake outputs and result payload.
    assign item.ready             = (state_reg == mpts_pkg::ST_IDLE);
    assign cfg.ready              = 1'b1;
    assign result.valid           = out_v_reg;
    assign result.clock_now       = out_clock_reg;
    assign result.running_valid   = out_run_v_reg;
    assign result.running_slot    = out_run_slot_reg;
    assign result.done_valid      = out_done_v_reg;
    assign result.done_slot       = out_done_slot_reg;
    assign result.done_wait       = out_wait_reg;
    assign result.done_response   = out_resp_reg;
    assign result.done_turnaround = out_turn_reg;
    assign result.all_done        = out_all_reg;
    assign result.busy_ticks      = out_busy_reg;
    assign result.load_error      = out_err_reg;

    // Sequencer: next state, table access and queue operations.
    always_comb
    begin
        logic          rm_en;
        logic [SW-1:0] rm_pos;
        logic          push_en;
        logic [SW-1:0] push_val;
        logic [IW-1:0] cnt;
        logic          found;
        logic [SW-1:0] fpos;
        logic [15:0]   key;
        logic [SW-1:0] s;
        logic [15:0]   rem_new;
        logic [CW-1:0] start_new;
        logic [CW-1:0] clk_inc;
        logic [7:0]    sl_dec;
        logic          expired;

        state_next        = state_reg;
        policy_next       = policy_reg;
        quantum_next      = quantum_reg;
        slot_next         = slot_reg;
        arr_next          = arr_reg;
        burst_next        = burst_reg;
        prio_next         = prio_reg;
        valid_next        = valid_reg;
        started_next      = started_reg;
        ready_next        = ready_reg;
        completed_next    = completed_reg;
        cur_v_next        = cur_v_reg;
        cur_slot_next     = cur_slot_reg;
        cur_prio_next     = cur_prio_reg;
        slice_next        = slice_reg;
        req_v_next        = req_v_reg;
        req_slot_next     = req_slot_reg;
        clock_next        = clock_reg;
        busy_next         = busy_reg;
        idx_next          = idx_reg;
        pend_next         = pend_reg;
        pidx_next         = pidx_reg;
        best_next         = best_reg;
        bp_next           = bp_reg;
        res_run_v_next    = res_run_v_reg;
        res_run_slot_next = res_run_slot_reg;
        res_done_v_next   = res_done_v_reg;
        res_done_slot_next = res_done_slot_reg;
        res_wait_next     = res_wait_reg;
        res_resp_next     = res_resp_reg;
        res_turn_next     = res_turn_reg;
        res_err_next      = res_err_reg;
        out_v_next        = out_v_reg;
        out_clock_next    = out_clock_reg;
        out_run_v_next    = out_run_v_reg;
        out_run_slot_next = out_run_slot_reg;
        out_done_v_next   = out_done_v_reg;
        out_done_slot_next = out_done_slot_reg;
        out_wait_next     = out_wait_reg;
        out_resp_next     = out_resp_reg;
        out_turn_next     = out_turn_reg;
        out_all_next      = out_all_reg;
        out_busy_next     = out_busy_reg;
        out_err_next      = out_err_reg;

        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = rd_data;
        rm_en    = 1'b0;
        rm_pos   = '0;
        push_en  = 1'b0;
        push_val = '0;
        found    = 1'b0;
        fpos     = '0;
        key      = '0;
        s        = q_reg[bp_reg];
        rem_new  = '0;
        start_new = '0;
        clk_inc  = mpts_pkg::sat_inc(clock_reg);
        sl_dec   = '0;
        expired  = 1'b0;

        // Configuration writes.
        if (cfg.valid)
        begin
            case (cfg.index)
                mpts_pkg::REG_POLICY:  policy_next  = cfg.data[1:0];
                mpts_pkg::REG_QUANTUM: quantum_next = cfg.data;
                default: ;
            endcase
        end

        // A taken result beat frees the output register.
        if (out_v_reg && result.ready)
        begin
            out_v_next = 1'b0;
        end

        case (state_reg)
            mpts_pkg::ST_IDLE:
            begin
                if (item.valid)
                begin
                    slot_next          = item.slot;
                    arr_next           = item.arrival;
                    burst_next         = item.burst;
                    prio_next          = item.prio;
                    res_run_v_next     = 1'b0;
                    res_run_slot_next  = '0;
                    res_done_v_next    = 1'b0;
                    res_done_slot_next = '0;
                    res_wait_next      = '0;
                    res_resp_next      = '0;
                    res_turn_next      = '0;
                    res_err_next       = 1'b0;
                    case (item.kind)
                        mpts_pkg::KIND_LOAD:
                        begin
                            state_next = mpts_pkg::ST_LOAD;
                        end
                        mpts_pkg::KIND_TICK:
                        begin
                            idx_next   = '0;
                            pend_next  = 1'b0;
                            state_next = mpts_pkg::ST_ADMIT;
                        end
                        mpts_pkg::KIND_RESTART:
                        begin
                            valid_next     = '0;
                            started_next   = '0;
                            ready_next     = '0;
                            completed_next = '0;
                            cur_v_next     = 1'b0;
                            slice_next     = '0;
                            req_v_next     = 1'b0;
                            clock_next     = '0;
                            busy_next      = '0;
                            state_next     = mpts_pkg::ST_FINISH;
                        end
                        default:
                        begin
                            state_next = mpts_pkg::ST_FINISH;
                        end
                    endcase
                end
            end

            // Load a slot, dropping it from every live position first; a zero burst only flags a load error.
            mpts_pkg::ST_LOAD:
            begin
                if (burst_reg == '0)
                begin
                    res_err_next = 1'b1;
                end
                else
                begin
                    for (int j = 0; j < SL; j++)
                    begin
                        if (!found && (IW'(j) < qcnt_reg) && (q_reg[j] == slot_reg))
                        begin
                            found = 1'b1;
                            fpos  = SW'(j);
                        end
                    end
                    rm_en  = found;
                    rm_pos = fpos;
                    if (cur_v_reg && (cur_slot_reg == slot_reg))
                    begin
                        cur_v_next = 1'b0;
                        slice_next = '0;
                    end
                    if (req_v_reg && (req_slot_reg == slot_reg))
                    begin
                        req_v_next = 1'b0;
                    end
                    valid_next[slot_reg]     = 1'b1;
                    started_next[slot_reg]   = 1'b0;
                    ready_next[slot_reg]     = 1'b0;
                    completed_next[slot_reg] = 1'b0;
                    wr_en             = 1'b1;
                    wr_addr           = slot_reg;
                    wr_data.arrival   = arr_reg;
                    wr_data.remaining = burst_reg;
                    wr_data.prio      = prio_reg;
                    wr_data.start     = '0;
                    wr_data.wait_cnt  = '0;
                end
                state_next = mpts_pkg::ST_FINISH;
            end

            // Sweep all slots in order and queue those arriving now.
            // A loaded slot that is not completed always has work left.
            mpts_pkg::ST_ADMIT:
            begin
                if (idx_reg < IW'(SL))
                begin
                    rd_addr   = idx_reg[SW-1:0];
                    pend_next = 1'b1;
                    pidx_next = idx_reg[SW-1:0];
                    idx_next  = idx_reg + 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = mpts_pkg::ST_REQUEUE;
                end
                if (pend_reg && valid_reg[pidx_reg] && !completed_reg[pidx_reg] &&
                    !ready_reg[pidx_reg] && ({8'd0, rd_data.arrival} == clock_reg) &&
                    !(cur_v_reg && (cur_slot_reg == pidx_reg)) &&
                    !(req_v_reg && (req_slot_reg == pidx_reg)))
                begin
                    push_en              = 1'b1;
                    push_val             = pidx_reg;
                    ready_next[pidx_reg] = 1'b1;
                end
            end

            // Put back a slot whose slice ran out on the previous tick.
            mpts_pkg::ST_REQUEUE:
            begin
                if (req_v_reg)
                begin
                    push_en                  = 1'b1;
                    push_val                 = req_slot_reg;
                    ready_next[req_slot_reg] = 1'b1;
                    req_v_next               = 1'b0;
                end
                state_next = mpts_pkg::ST_DECIDE;
            end

            mpts_pkg::ST_DECIDE:
            begin
                if ((qcnt_reg != '0) && ((policy_reg == mpts_pkg::POL_PRIO) || !cur_v_reg))
                begin
                    if ((policy_reg == mpts_pkg::POL_SJF) ||
                        (policy_reg == mpts_pkg::POL_PRIO))
                    begin
                        idx_next   = '0;
                        pend_next  = 1'b0;
                        state_next = mpts_pkg::ST_SELECT;
                    end
                    else
                    begin
                        bp_next    = '0;
                        state_next = mpts_pkg::ST_TAKE;
                    end
                end
                else
                begin
                    state_next = mpts_pkg::ST_RUN_RD;
                end
            end

            // Walk the queue for the smallest key; ties keep the earlier entry.
            mpts_pkg::ST_SELECT:
            begin
                if (idx_reg < qcnt_reg)
                begin
                    rd_addr   = q_reg[idx_reg[SW-1:0]];
                    pend_next = 1'b1;
                    pidx_next = idx_reg[SW-1:0];
                    idx_next  = idx_reg + 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = mpts_pkg::ST_TAKE;
                end
                key = (policy_reg == mpts_pkg::POL_PRIO) ? {8'd0, rd_data.prio}
                                                         : rd_data.remaining;
                if (pend_reg && ((pidx_reg == '0) || (key < best_reg)))
                begin
                    best_next = key;
                    bp_next   = pidx_reg;
                end
            end

            // Dispatch the chosen entry, preempting in priority mode.
            mpts_pkg::ST_TAKE:
            begin
                if ((policy_reg == mpts_pkg::POL_PRIO) && cur_v_reg)
                begin
                    if (best_reg < {8'd0, cur_prio_reg})
                    begin
                        rm_en                    = 1'b1;
                        rm_pos                   = bp_reg;
                        push_en                  = 1'b1;
                        push_val                 = cur_slot_reg;
                        ready_next[s]            = 1'b0;
                        ready_next[cur_slot_reg] = 1'b1;
                        cur_slot_next            = s;
                    end
                end
                else
                begin
                    rm_en         = 1'b1;
                    rm_pos        = bp_reg;
                    ready_next[s] = 1'b0;
                    cur_v_next    = 1'b1;
                    cur_slot_next = s;
                    if (policy_reg == mpts_pkg::POL_RR)
                    begin
                        slice_next = (quantum_reg == '0) ? 8'd1 : quantum_reg;
                    end
                end
                state_next = mpts_pkg::ST_RUN_RD;
            end

            mpts_pkg::ST_RUN_RD:
            begin
                rd_addr  = cur_slot_reg;
                idx_next = '0;
                state_next = cur_v_reg ? mpts_pkg::ST_RUN_WR : mpts_pkg::ST_WAIT_RD;
            end

            // Run one unit of the current slot and check for completion or slice expiry.
            mpts_pkg::ST_RUN_WR:
            begin
                rem_new   = (rd_data.remaining != '0) ? rd_data.remaining - 1'b1 : '0;
                start_new = started_reg[cur_slot_reg] ? rd_data.start : clock_reg;
                started_next[cur_slot_reg] = 1'b1;
                wr_en             = 1'b1;
                wr_addr           = cur_slot_reg;
                wr_data.remaining = rem_new;
                wr_data.start     = start_new;
                cur_prio_next     = rd_data.prio;
                busy_next         = mpts_pkg::sat_inc(busy_reg);
                res_run_v_next    = 1'b1;
                res_run_slot_next = cur_slot_reg;
                if (policy_reg == mpts_pkg::POL_RR)
                begin
                    sl_dec     = (slice_reg != '0) ? slice_reg - 1'b1 : '0;
                    expired    = (sl_dec == '0);
                    slice_next = sl_dec;
                end
                if (rem_new == '0)
                begin
                    completed_next[cur_slot_reg] = 1'b1;
                    res_done_v_next    = 1'b1;
                    res_done_slot_next = cur_slot_reg;
                    res_wait_next      = rd_data.wait_cnt;
                    res_resp_next      = (start_new >= {8'd0, rd_data.arrival}) ?
                                         start_new - {8'd0, rd_data.arrival} : '0;
                    res_turn_next      = (clk_inc >= {8'd0, rd_data.arrival}) ?
                                         clk_inc - {8'd0, rd_data.arrival} : '0;
                    cur_v_next         = 1'b0;
                    slice_next         = '0;
                end
                else if (expired)
                begin
                    req_v_next    = 1'b1;
                    req_slot_next = cur_slot_reg;
                    cur_v_next    = 1'b0;
                    slice_next    = '0;
                end
                state_next = mpts_pkg::ST_WAIT_RD;
            end

            // Charge one wait tick to each queued slot, then advance time.
            mpts_pkg::ST_WAIT_RD:
            begin
                if (idx_reg < qcnt_reg)
                begin
                    rd_addr    = q_reg[idx_reg[SW-1:0]];
                    state_next = mpts_pkg::ST_WAIT_WR;
                end
                else
                begin
                    clock_next = clk_inc;
                    state_next = mpts_pkg::ST_FINISH;
                end
            end

            mpts_pkg::ST_WAIT_WR:
            begin
                wr_en            = 1'b1;
                wr_addr          = q_reg[idx_reg[SW-1:0]];
                wr_data.wait_cnt = mpts_pkg::sat_inc(rd_data.wait_cnt);
                idx_next         = idx_reg + 1'b1;
                state_next       = mpts_pkg::ST_WAIT_RD;
            end

            // Move the result into the output register once it is free.
            mpts_pkg::ST_FINISH:
            begin
                if (!out_v_reg || result.ready)
                begin
                    out_v_next         = 1'b1;
                    out_clock_next     = clock_reg;
                    out_run_v_next     = res_run_v_reg;
                    out_run_slot_next  = res_run_slot_reg;
                    out_done_v_next    = res_done_v_reg;
                    out_done_slot_next = res_done_slot_reg;
                    out_wait_next      = res_wait_reg;
                    out_resp_next      = res_resp_reg;
                    out_turn_next      = res_turn_reg;
                    out_all_next       = ((valid_reg & ~completed_reg) == '0);
                    out_busy_next      = busy_reg;
                    out_err_next       = res_err_reg;
                    state_next         = mpts_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mpts_pkg::ST_IDLE;
            end
        endcase

        // Ready queue update: optional removal with shift, then optional push.
        q_next = q_reg;
        cnt    = qcnt_reg;
        if (rm_en)
        begin
            for (int j = 0; j < SL - 1; j++)
            begin
                if (SW'(j) >= rm_pos)
                begin
                    q_next[j] = q_reg[j + 1];
                end
            end
            cnt = cnt - 1'b1;
        end
        if (push_en && (cnt < IW'(SL)))
        begin
            q_next[cnt[SW-1:0]] = push_val;
            cnt = cnt + 1'b1;
        end
        qcnt_next = cnt;
        // Restart empties the queue.
        if ((state_reg == mpts_pkg::ST_IDLE) && item.valid &&
            (item.kind == mpts_pkg::KIND_RESTART))
        begin
            qcnt_next = '0;
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= mpts_pkg::ST_IDLE;
            policy_reg        <= mpts_pkg::POL_FCFS;
            quantum_reg       <= 8'd2;
            valid_reg         <= '0;
            started_reg       <= '0;
            ready_reg         <= '0;
            completed_reg     <= '0;
            qcnt_reg          <= '0;
            cur_v_reg         <= 1'b0;
            slice_reg         <= '0;
            req_v_reg         <= 1'b0;
            clock_reg         <= '0;
            busy_reg          <= '0;
            idx_reg           <= '0;
            pend_reg          <= 1'b0;
            out_v_reg         <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            policy_reg        <= policy_next;
            quantum_reg       <= quantum_next;
            valid_reg         <= valid_next;
            started_reg       <= started_next;
            ready_reg         <= ready_next;
            completed_reg     <= completed_next;
            qcnt_reg          <= qcnt_next;
            cur_v_reg         <= cur_v_next;
            slice_reg         <= slice_next;
            req_v_reg         <= req_v_next;
            clock_reg         <= clock_next;
            busy_reg          <= busy_next;
            idx_reg           <= idx_next;
            pend_reg          <= pend_next;
            out_v_reg         <= out_v_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        slot_reg           <= slot_next;
        arr_reg            <= arr_next;
        burst_reg          <= burst_next;
        prio_reg           <= prio_next;
        q_reg              <= q_next;
        cur_slot_reg       <= cur_slot_next;
        cur_prio_reg       <= cur_prio_next;
        req_slot_reg       <= req_slot_next;
        pidx_reg           <= pidx_next;
        best_reg           <= best_next;
        bp_reg             <= bp_next;
        res_run_v_reg      <= res_run_v_next;
        res_run_slot_reg   <= res_run_slot_next;
        res_done_v_reg     <= res_done_v_next;
        res_done_slot_reg  <= res_done_slot_next;
        res_wait_reg       <= res_wait_next;
        res_resp_reg       <= res_resp_next;
        res_turn_reg       <= res_turn_next;
        res_err_reg        <= res_err_next;
        out_clock_reg      <= out_clock_next;
        out_run_v_reg      <= out_run_v_next;
        out_run_slot_reg   <= out_run_slot_next;
        out_done_v_reg     <= out_done_v_next;
        out_done_slot_reg  <= out_done_slot_next;
        out_wait_reg       <= out_wait_next;
        out_resp_reg       <= out_resp_next;
        out_turn_reg       <= out_turn_next;
        out_all_reg        <= out_all_next;
        out_busy_reg       <= out_busy_next;
        out_err_reg        <= out_err_next;
    end

endmodule

`default_nettype wire

// File: bench/mpts_sched_tb_if.sv
`timescale 1ns / 1ps

// The channel interfaces are declared with the RTL; this file only holds the
// beat record that the bench passes between its monitor and its scoreboard.
package mpts_tb_pkg;

    // One result beat.
    typedef struct packed {
        logic [23:0] clock_now;
        logic        running_valid;
        logic [3:0]  running_slot;
        logic        done_valid;
        logic [3:0]  done_slot;
        logic [23:0] done_wait;
        logic [23:0] done_response;
        logic [23:0] done_turnaround;
        logic        all_done;
        logic [23:0] busy_ticks;
        logic        load_error;
    } status_t;

endpackage

// File: bench/multi_policy_tick_scheduler_top_test.sv
`timescale 1ns / 1ps

module multi_policy_tick_scheduler_top_test;

    localparam logic [23:0] SAT = 24'hFFFFFF;

    // Scheduler model with its own state and the queue of predicted statuses.
    class sched_scoreboard;
        logic [1:0]  pol;
        logic [7:0]  qnt;
        bit          live [16];
        logic [15:0] arr [16];
        logic [15:0] rem [16];
        logic [7:0]  pri [16];
        logic [23:0] st [16];
        logic [23:0] wt [16];
        bit          started [16];
        bit          queued [16];
        bit          finished [16];
        int          rq [$];
        bit          run_v;
        int          run_s;
        int          slice;
        bit          req_v;
        int          req_s;
        logic [23:0] now;
        logic [23:0] busy;
        mpts_tb_pkg::status_t pending [$];
        int          errors;

        function new();
            pol = mpts_pkg::POL_FCFS;
            qnt = 8'd2;
            errors = 0;
            wipe();
        endfunction

        function void wipe();
            for (int i = 0; i < 16; i++)
            begin
                live[i] = 0; started[i] = 0; queued[i] = 0; finished[i] = 0;
                arr[i] = 0; rem[i] = 0; pri[i] = 0; st[i] = 0; wt[i] = 0;
            end
            rq.delete();
            run_v = 0; run_s = 0; slice = 0; req_v = 0; req_s = 0;
            now = 0; busy = 0;
        endfunction

        function logic [23:0] inc(logic [23:0] v);
            return (v == SAT) ? SAT : v + 24'd1;
        endfunction

        function void push(int s);
            if (rq.size() < 16)
            begin
                rq.push_back(s);
                queued[s] = 1;
            end
        endfunction

        function void take(int pos);
            queued[rq[pos]] = 0;
            rq.delete(pos);
        endfunction

        function void start_run(int s);
            run_v = 1;
            run_s = s;
            if (!started[s])
            begin
                started[s] = 1;
                st[s] = now;
            end
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] d);
            if (idx == mpts_pkg::REG_POLICY) pol = d[1:0];
            else if (idx == mpts_pkg::REG_QUANTUM) qnt = d;
        endfunction

        // Predicts the status beat for one accepted item.
        function void note_item(logic [1:0] kind, logic [3:0] slot, logic [15:0] a,
                                logic [15:0] b, logic [7:0] p);
            mpts_tb_pkg::status_t r;
            int bp;
            int s;
            bit expired;
            r = '0;
            expired = 0;
            if (kind == mpts_pkg::KIND_LOAD)
            begin
                if (b == 0) r.load_error = 1;
                else
                begin
                    s = slot;
                    for (int k = 0; k < rq.size(); k++)
                        if (rq[k] == s)
                        begin
                            take(k);
                            break;
                        end
                    if (run_v && run_s == s)
                    begin
                        run_v = 0;
                        slice = 0;
                    end
                    if (req_v && req_s == s) req_v = 0;
                    live[s] = 1; arr[s] = a; rem[s] = b; pri[s] = p;
                    st[s] = 0; wt[s] = 0;
                    started[s] = 0; queued[s] = 0; finished[s] = 0;
                end
            end
            else if (kind == mpts_pkg::KIND_RESTART) wipe();
            else if (kind == mpts_pkg::KIND_TICK)
            begin
                // Admission in slot order, then the round-robin requeue.
                for (int i = 0; i < 16; i++)
                    if (live[i] && !finished[i] && !queued[i] && rem[i] > 0 &&
                        {8'd0, arr[i]} == now && !(run_v && run_s == i) &&
                        !(req_v && req_s == i))
                        push(i);
                if (req_v)
                begin
                    push(req_s);
                    req_v = 0;
                end
                // Selection.
                if (pol == mpts_pkg::POL_PRIO)
                begin
                    if (rq.size() > 0)
                    begin
                        bp = 0;
                        for (int k = 1; k < rq.size(); k++)
                            if (pri[rq[k]] < pri[rq[bp]]) bp = k;
                        if (!run_v)
                        begin
                            s = rq[bp];
                            take(bp);
                            start_run(s);
                        end
                        else if (pri[rq[bp]] < pri[run_s])
                        begin
                            s = rq[bp];
                            take(bp);
                            push(run_s);
                            start_run(s);
                        end
                    end
                end
                else if (!run_v && rq.size() > 0)
                begin
                    bp = 0;
                    if (pol == mpts_pkg::POL_SJF)
                        for (int k = 1; k < rq.size(); k++)
                            if (rem[rq[k]] < rem[rq[bp]]) bp = k;
                    s = rq[bp];
                    take(bp);
                    start_run(s);
                    if (pol == mpts_pkg::POL_RR) slice = (qnt == 0) ? 1 : qnt;
                end
                // Run one unit and charge the queue.
                if (run_v)
                begin
                    r.running_valid = 1;
                    r.running_slot = run_s;
                    if (rem[run_s] > 0) rem[run_s]--;
                    busy = inc(busy);
                    if (pol == mpts_pkg::POL_RR)
                    begin
                        if (slice > 0) slice--;
                        expired = (slice == 0);
                    end
                end
                foreach (rq[k]) wt[rq[k]] = inc(wt[rq[k]]);
                now = inc(now);
                if (run_v)
                begin
                    s = run_s;
                    if (rem[s] == 0)
                    begin
                        finished[s] = 1;
                        r.done_valid = 1;
                        r.done_slot = s;
                        r.done_wait = wt[s];
                        r.done_response = (st[s] >= arr[s]) ? st[s] - arr[s] : 0;
                        r.done_turnaround = (now >= arr[s]) ? now - arr[s] : 0;
                        run_v = 0;
                        slice = 0;
                    end
                    else if (expired)
                    begin
                        req_v = 1;
                        req_s = s;
                        run_v = 0;
                        slice = 0;
                    end
                end
            end
            r.clock_now = now;
            r.busy_ticks = busy;
            r.all_done = 1;
            for (int i = 0; i < 16; i++)
                if (live[i] && !finished[i]) r.all_done = 0;
            pending.push_back(r);
        endfunction

        // Compares one result beat with the oldest prediction.
        function void check_result(mpts_tb_pkg::status_t got);
            mpts_tb_pkg::status_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("Unexpected result beat %h", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e)
            begin
                errors++;
                if (errors <= 10)
                    $display("Mismatch at clock %0d: expected %p, actual %p",
                             e.clock_now, e, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    mpts_item_if   item ();
    mpts_result_if result ();
    mpts_cfg_if    cfg ();

    multi_policy_tick_scheduler_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    sched_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_cycles;
    longint cycles;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        item.valid = 0; item.kind = 0; item.slot = 0; item.arrival = 0;
        item.burst = 0; item.prio = 0;
        cfg.valid = 0; cfg.index = 0; cfg.data = 0;
        result.ready = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        cycles = 0;
    end

    // Cycle counter with a generous timeout.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: random stalls plus an optional long hold-off.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            result.ready <= 1'b0;
        end
        else
            result.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
            sb.check_result('{result.clock_now, result.running_valid, result.running_slot,
                              result.done_valid, result.done_slot, result.done_wait,
                              result.done_response, result.done_turnaround,
                              result.all_done, result.busy_ticks, result.load_error});
    end

    // Sends one item beat and records the prediction on acceptance. Valid drops
    // for the edge after acceptance, while the block is still busy with the item.
    task automatic send_item(logic [1:0] kind, logic [3:0] slot, logic [15:0] a,
                             logic [15:0] b, logic [7:0] p);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        item.valid <= 1'b1;
        item.kind <= kind;
        item.slot <= slot;
        item.arrival <= a;
        item.burst <= b;
        item.prio <= p;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        sb.note_item(kind, slot, a, b, p);
        item.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] d);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= d;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        sb.set_reg(idx, d);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits for every predicted beat, then lets the block settle.
    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic tick();
        send_item(mpts_pkg::KIND_TICK, $urandom, $urandom, $urandom, $urandom);
    endtask

    // A restart followed by a small job set with arrivals near zero, then ticks.
    task automatic job_set(int n_jobs, int n_ticks);
        send_item(mpts_pkg::KIND_RESTART, $urandom, $urandom, $urandom, $urandom);
        for (int j = 0; j < n_jobs; j++)
        begin
            if ($urandom_range(19) == 0)
                send_item(mpts_pkg::KIND_LOAD, $urandom, $urandom, 16'd0, $urandom);
            else
                send_item(mpts_pkg::KIND_LOAD, $urandom, $urandom_range(8),
                          ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 5),
                          $urandom_range(3) == 0 ? $urandom : $urandom_range(3));
        end
        for (int t = 0; t < n_ticks; t++)
        begin
            // Occasional reload of a slot while the set is running.
            if ($urandom_range(29) == 0)
                send_item(mpts_pkg::KIND_LOAD, $urandom, sb.now[15:0] + $urandom_range(2),
                          $urandom_range(1, 4), $urandom);
            else if ($urandom_range(49) == 0)
                send_item(mpts_pkg::KIND_UNKNOWN, $urandom, $urandom, $urandom, $urandom);
            else
                tick();
        end
    endtask

    int sent;

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every kind, zero burst, reload, unknown kind.
        send_item(mpts_pkg::KIND_LOAD, 4'd0, 16'd0, 16'd3, 8'd0);
        send_item(mpts_pkg::KIND_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_item(mpts_pkg::KIND_LOAD, 4'd5, 16'd1, 16'd0, 8'd7);
        send_item(mpts_pkg::KIND_LOAD, 4'd3, 16'd1, 16'd2, 8'd1);
        send_item(mpts_pkg::KIND_UNKNOWN, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF);
        repeat (3) tick();
        send_item(mpts_pkg::KIND_LOAD, 4'd3, 16'd4, 16'd1, 8'd2);
        repeat (6) tick();
        send_item(mpts_pkg::KIND_RESTART, 4'hA, 16'h5555, 16'hAAAA, 8'h55);
        send_item(mpts_pkg::KIND_LOAD, 4'd1, 16'd0, 16'd2, 8'd9);
        send_item(mpts_pkg::KIND_LOAD, 4'd2, 16'd0, 16'd1, 8'd3);
        repeat (4) tick();
        drain();

        // Random phases across policies and quantum extremes.
        sent = 0;
        for (int ph = 0; sent < 1000; ph++)
        begin
            write_reg(mpts_pkg::REG_POLICY, ph % 4);
            case (ph % 5)
                0: write_reg(mpts_pkg::REG_QUANTUM, 8'd0);
                1: write_reg(mpts_pkg::REG_QUANTUM, 8'd1);
                2: write_reg(mpts_pkg::REG_QUANTUM, 8'd255);
                default: write_reg(mpts_pkg::REG_QUANTUM, $urandom_range(2, 4));
            endcase
            case ((ph / 4) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            if (ph == 2) hold_cycles = 600;
            begin
                int nj;
                int nt;
                nj = $urandom_range(1, 6);
                nt = $urandom_range(10, 30);
                job_set(nj, nt);
                sent += nj + nt + 1;
            end
            // Policy changes while jobs are in flight.
            if (ph % 3 == 0)
            begin
                drain();
                write_reg(mpts_pkg::REG_POLICY, $urandom);
                repeat (8) tick();
                sent += 8;
            end
            drain();
        end

        // Saturation of the clock is not driven: it would take too many ticks. The directed
        // load of slot 15 covers the upper field values. This phase only drains the block.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
